// ----- src/lesd_pkg.sv -----
// Shared types and constants for the load event state detector.
// No dependencies; every other file in src imports this package.
`default_nettype none

package lesd_pkg;

  localparam int NUM_SENSORS  = 4;
  localparam int READING_W    = 10;
  localparam int MAX_READING  = 1000;
  localparam int INIT_SAMPLES = 16;

  localparam int DELTA_W    = 13;
  // One extra bit so that delta plus or minus the threshold never wraps.
  localparam int CMP_W      = DELTA_W + 1;
  localparam int THRESH_W   = 12;
  localparam int STABLE_W   = 8;
  localparam int WEIGH_W    = 7;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam int ZSUM_W = $clog2(INIT_SAMPLES * MAX_READING + 1);
  localparam int ZCNT_W = $clog2(INIT_SAMPLES + 1);

  typedef logic [READING_W-1:0] reading_t;
  typedef reading_t [NUM_SENSORS-1:0] reading_vec_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [CMP_W-1:0] cmp_t;
  typedef logic [ZSUM_W-1:0] zsum_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_INIT        = 3'd1,
    PH_READY       = 3'd2,
    PH_LOADING     = 3'd3,
    PH_UNLOADING   = 3'd4,
    PH_STABILIZING = 3'd5,
    PH_WEIGHTING   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_LOAD   = 2'd1,
    DIR_UNLOAD = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_STABLE    = 2'd1,
    REG_WEIGH     = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/load_event_state_detector_unit.sv -----
// Top level of the load event state detector: handshake, configuration and phase machine.
// Depends on lesd_pkg and lesd_delta.
`default_nettype none

//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  sample   | sample_valid/sample_stall, sensor_0..3,  | in
//           | restart                                  |
//  result   | result_valid/result_stall, frame_valid,  | out
//           | phase, total_delta, peak_delta,          |
//           | baseline_delta, weigh_strobe,            |
//           | collection_done                          |
//  config   | cfg_write, cfg_index, cfg_data           | in
//
// One frame per cycle is accepted while sample_stall is low. A frame is registered
// on entry in the input register, then evaluated and written to the result register
// once that register can take it. The input register holds a frame while the result
// register is full and stalled, and sample_stall rises only then. Reset clears the
// phase machine, calibration and the configuration registers to their defaults.

module load_event_state_detector_unit import lesd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire logic [READING_W-1:0]  sensor_0,
  input  wire logic [READING_W-1:0]  sensor_1,
  input  wire logic [READING_W-1:0]  sensor_2,
  input  wire logic [READING_W-1:0]  sensor_3,
  input  wire logic                  restart,

  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic                       frame_valid,
  output logic [2:0]                 phase,
  output logic signed [DELTA_W-1:0]  total_delta,
  output logic signed [DELTA_W-1:0]  peak_delta,
  output logic signed [DELTA_W-1:0]  baseline_delta,
  output logic                       weigh_strobe,
  output logic                       collection_done,

  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [THRESH_W-1:0] event_thresh;
  logic [STABLE_W-1:0] stable_frames;
  logic [WEIGH_W-1:0]  weighing_frames;

  // Input register.
  logic         s1_valid;
  reading_vec_t s1_readings;
  logic         s1_restart;

  // Algorithm state.
  phase_t              phase_reg;
  delta_t              peak_reg;
  delta_t              valley_reg;
  delta_t              baseline_reg;
  dir_t                last_direction;
  logic [STABLE_W-1:0] stable_count;
  zsum_t               zero_sums [NUM_SENSORS];
  logic [ZCNT_W-1:0]   zero_count;
  reading_vec_t        zero_levels;
  logic                calibrated;
  logic                calib_pending;
  logic [WEIGH_W-1:0]  weigh_count;
  logic                collect_complete;
  logic                estimate_done;

  // State as seen after a restart request has been applied.
  phase_t              ph_cur;
  delta_t              peak_cur;
  dir_t                dir_cur;
  logic [STABLE_W-1:0] sc_cur;
  zsum_t               sums_cur [NUM_SENSORS];
  logic [ZCNT_W-1:0]   count_cur;
  logic                cal_cur;
  logic [WEIGH_W-1:0]  wc_cur;
  logic                cc_cur;
  logic                est_cur;

  // Next values.
  phase_t              phase_reg_next;
  delta_t              peak_reg_next;
  delta_t              valley_reg_next;
  delta_t              baseline_reg_next;
  dir_t                last_direction_next;
  logic [STABLE_W-1:0] stable_count_next;
  zsum_t               zero_sums_next [NUM_SENSORS];
  logic [ZCNT_W-1:0]   zero_count_next;
  reading_vec_t        zero_levels_next;
  logic                calibrated_next;
  logic                calib_pending_next;
  logic [WEIGH_W-1:0]  weigh_count_next;
  logic                collect_complete_next;
  logic                estimate_done_next;
  logic                strobe_next;

  logic   frame_ok;
  delta_t delta;
  logic   out_ready;
  logic   fire;

  cmp_t d_ext, th_ext;
  logic ge_base, le_base, ge_peak, le_valley, ge_peak_th, le_valley_th;
  logic                stab_extreme;
  logic [STABLE_W-1:0] stab_count;
  logic                stab_done;

  // Handshake: the input register refills whenever its frame moves on.
  assign out_ready    = !result_valid || !result_stall;
  assign fire         = s1_valid && out_ready;
  assign sample_stall = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
    if (sample_valid && !sample_stall) begin
      s1_readings <= {sensor_3, sensor_2, sensor_1, sensor_0};
      s1_restart  <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_thresh    <= THRESH_W'(100);
      stable_frames   <= STABLE_W'(5);
      weighing_frames <= WEIGH_W'(10);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: event_thresh    <= cfg_data[THRESH_W-1:0];
        REG_STABLE:    stable_frames   <= cfg_data[STABLE_W-1:0];
        REG_WEIGH:     weighing_frames <= cfg_data[WEIGH_W-1:0];
        default: ;
      endcase
    end
  end

  lesd_delta u_delta (
    .readings    (s1_readings),
    .zero_levels (zero_levels),
    .frame_ok    (frame_ok),
    .delta       (delta)
  );

  // A restart clears part of the state before the frame itself is evaluated.
  always_comb begin
    ph_cur    = s1_restart ? PH_IDLE  : phase_reg;
    peak_cur  = s1_restart ? '0       : peak_reg;
    dir_cur   = s1_restart ? DIR_NONE : last_direction;
    sc_cur    = s1_restart ? '0       : stable_count;
    count_cur = s1_restart ? '0       : zero_count;
    cal_cur   = s1_restart ? 1'b0     : calibrated;
    wc_cur    = s1_restart ? '0       : weigh_count;
    cc_cur    = s1_restart ? 1'b0     : collect_complete;
    est_cur   = s1_restart ? 1'b0     : estimate_done;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sums_cur[i] = s1_restart ? '0 : zero_sums[i];
    end
  end

  assign d_ext        = CMP_W'(delta);
  assign th_ext       = cmp_t'({1'b0, event_thresh});
  assign ge_base      = d_ext >= CMP_W'(baseline_reg) + th_ext;
  assign le_base      = d_ext <= CMP_W'(baseline_reg) - th_ext;
  assign ge_peak      = delta >= peak_cur;
  assign le_valley    = delta <= valley_reg;
  assign ge_peak_th   = d_ext >= CMP_W'(peak_cur) + th_ext;
  assign le_valley_th = d_ext <= CMP_W'(valley_reg) - th_ext;

  // While stabilizing, a new extreme in the last direction restarts the event.
  assign stab_extreme = (dir_cur == DIR_LOAD && ge_peak) ||
                        (dir_cur == DIR_UNLOAD && le_valley);
  always_comb begin
    if (stab_extreme) begin
      stab_count = '0;
    end else if (dir_cur == DIR_LOAD || dir_cur == DIR_UNLOAD) begin
      stab_count = sc_cur + STABLE_W'(1);
    end else begin
      stab_count = sc_cur;
    end
  end
  assign stab_done = stab_count >= stable_frames;

  // Next phase.
  always_comb begin
    phase_reg_next = ph_cur;
    if (frame_ok) begin
      unique case (ph_cur)
        PH_IDLE: phase_reg_next = PH_INIT;
        PH_INIT: begin
          if (calib_pending) phase_reg_next = PH_READY;
        end
        PH_READY: begin
          if (ge_base) begin
            phase_reg_next = PH_LOADING;
          end else if (le_base) begin
            phase_reg_next = PH_UNLOADING;
          end
        end
        PH_LOADING: begin
          if (!ge_peak) phase_reg_next = PH_STABILIZING;
        end
        PH_UNLOADING: begin
          if (!le_valley) phase_reg_next = PH_STABILIZING;
        end
        PH_STABILIZING: begin
          if (stab_done) begin
            phase_reg_next = PH_WEIGHTING;
          end else if (stab_extreme) begin
            phase_reg_next = (dir_cur == DIR_LOAD) ? PH_LOADING : PH_UNLOADING;
          end
        end
        default: begin
          if (est_cur) begin
            phase_reg_next = PH_READY;
          end else if (ge_peak_th) begin
            phase_reg_next = PH_LOADING;
          end else if (le_valley_th) begin
            phase_reg_next = PH_UNLOADING;
          end
        end
      endcase
    end
  end

  // Tracking, calibration and weighting state.
  always_comb begin
    peak_reg_next         = peak_cur;
    valley_reg_next       = valley_reg;
    baseline_reg_next     = baseline_reg;
    last_direction_next   = dir_cur;
    stable_count_next     = sc_cur;
    zero_count_next       = count_cur;
    zero_levels_next      = zero_levels;
    calibrated_next       = cal_cur;
    calib_pending_next    = calib_pending;
    weigh_count_next      = wc_cur;
    collect_complete_next = cc_cur;
    estimate_done_next    = est_cur;
    strobe_next           = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      zero_sums_next[i] = sums_cur[i];
    end

    if (frame_ok) begin
      unique case (ph_cur)
        PH_IDLE: peak_reg_next = '0;
        PH_INIT: begin
          if (calib_pending) calib_pending_next = 1'b0;
        end
        PH_READY: begin
          if (ge_base) begin
            peak_reg_next       = delta;
            last_direction_next = DIR_LOAD;
            stable_count_next   = '0;
          end else if (le_base) begin
            valley_reg_next     = delta;
            last_direction_next = DIR_UNLOAD;
            stable_count_next   = '0;
          end
        end
        PH_LOADING: begin
          last_direction_next = DIR_LOAD;
          stable_count_next   = '0;
          if (ge_peak) peak_reg_next = delta;
        end
        PH_UNLOADING: begin
          last_direction_next = DIR_UNLOAD;
          stable_count_next   = '0;
          if (le_valley) valley_reg_next = delta;
        end
        PH_STABILIZING: begin
          stable_count_next = stab_done ? '0 : stab_count;
          if (stab_extreme && dir_cur == DIR_LOAD) peak_reg_next = delta;
          if (stab_extreme && dir_cur == DIR_UNLOAD) valley_reg_next = delta;
        end
        default: begin
          if (est_cur) begin
            estimate_done_next = 1'b0;
            baseline_reg_next  = delta;
            peak_reg_next      = delta;
            valley_reg_next    = delta;
            stable_count_next  = '0;
          end else if (ge_peak_th) begin
            peak_reg_next       = delta;
            last_direction_next = DIR_LOAD;
            stable_count_next   = '0;
            weigh_count_next    = '0;
          end else if (le_valley_th) begin
            valley_reg_next     = delta;
            last_direction_next = DIR_UNLOAD;
            stable_count_next   = '0;
            weigh_count_next    = '0;
          end
        end
      endcase

      // Follow-up work depends on the phase the frame lands in.
      priority if (phase_reg_next == PH_READY) begin
        weigh_count_next = '0;
      end else if (phase_reg_next == PH_INIT) begin
        if (!cal_cur && count_cur < ZCNT_W'(INIT_SAMPLES)) begin
          for (int i = 0; i < NUM_SENSORS; i++) begin
            zero_sums_next[i] = sums_cur[i] + ZSUM_W'(s1_readings[i]);
          end
          zero_count_next = count_cur + ZCNT_W'(1);
          if (zero_count_next == ZCNT_W'(INIT_SAMPLES)) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
              zero_levels_next[i] = READING_W'(zero_sums_next[i] / INIT_SAMPLES);
            end
            calibrated_next    = 1'b1;
            calib_pending_next = 1'b1;
          end
        end
      end else if (phase_reg_next == PH_WEIGHTING) begin
        if (cc_cur) begin
          estimate_done_next    = 1'b1;
          collect_complete_next = 1'b0;
        end else begin
          strobe_next = 1'b1;
          if (wc_cur < weighing_frames) weigh_count_next = wc_cur + WEIGH_W'(1);
          if (weigh_count_next >= weighing_frames) collect_complete_next = 1'b1;
        end
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_IDLE;
      peak_reg         <= '0;
      valley_reg       <= '0;
      baseline_reg     <= '0;
      last_direction   <= DIR_NONE;
      stable_count     <= '0;
      zero_count       <= '0;
      zero_levels      <= '0;
      calibrated       <= 1'b0;
      calib_pending    <= 1'b0;
      weigh_count      <= '0;
      collect_complete <= 1'b0;
      estimate_done    <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        zero_sums[i] <= '0;
      end
    end else if (fire) begin
      phase_reg        <= phase_reg_next;
      peak_reg         <= peak_reg_next;
      valley_reg       <= valley_reg_next;
      baseline_reg     <= baseline_reg_next;
      last_direction   <= last_direction_next;
      stable_count     <= stable_count_next;
      zero_count       <= zero_count_next;
      zero_levels      <= zero_levels_next;
      calibrated       <= calibrated_next;
      calib_pending    <= calib_pending_next;
      weigh_count      <= weigh_count_next;
      collect_complete <= collect_complete_next;
      estimate_done    <= estimate_done_next;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        zero_sums[i] <= zero_sums_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s1_valid;
    end
    if (fire) begin
      frame_valid     <= frame_ok;
      phase           <= phase_reg_next;
      total_delta     <= delta;
      peak_delta      <= peak_reg_next;
      baseline_delta  <= baseline_reg_next;
      weigh_strobe    <= strobe_next;
      collection_done <= collect_complete_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/lesd_delta.sv -----
// Frame range check and total delta over the calibrated sensors.
// Depends on lesd_pkg.
`default_nettype none

module lesd_delta import lesd_pkg::*; (
  input  wire reading_vec_t readings,
  input  wire reading_vec_t zero_levels,
  output logic              frame_ok,
  output delta_t            delta
);

  delta_t sum;

  always_comb begin
    frame_ok = 1'b1;
    sum      = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (readings[i] == '0 || readings[i] > READING_W'(MAX_READING)) begin
        frame_ok = 1'b0;
      end
      // A sensor with a zero level of zero is treated as uncalibrated.
      if (zero_levels[i] != '0) begin
        sum = sum + (DELTA_W'(zero_levels[i]) - DELTA_W'(readings[i]));
      end
    end
  end

  // An out-of-range frame reports no delta.
  assign delta = frame_ok ? sum : '0;

endmodule

`default_nettype wire
